// File: rtl/sspc_pkg.sv
// shared types and constants for the stepper and solenoid pulse controller
package sspc_pkg;

  localparam int unsigned STEP_W   = 16;
  localparam int unsigned PULSE_W  = 32;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned COILS    = 4;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [STEP_W-1:0]  STEP_PERIOD_RST  = 16'd2000;
  localparam logic [PULSE_W-1:0] PULSE_LENGTH_RST = 32'd30000;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH = 1'd1;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_PULSE  = 2'd1,
    KIND_TARGET = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic [STEP_W-1:0]        elapsed;
    logic signed [POS_W-1:0]  target_position;
  } in_item_t;

  typedef struct packed {
    logic [COILS-1:0]         coils;
    logic                     solenoid_drive;
    logic signed [POS_W-1:0]  current_position;
  } out_item_t;

endpackage

// File: rtl/sspc_stepper.sv
// stepper state: wait accumulator, position, target and wave-drive coil select
module sspc_stepper (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   upd,
  input  sspc_pkg::in_item_t                     item,
  input  logic [sspc_pkg::STEP_W-1:0]            step_period,
  output logic [sspc_pkg::COILS-1:0]             coils_nxt,
  output logic signed [sspc_pkg::POS_W-1:0]      position_nxt
);

  logic signed [sspc_pkg::POS_W-1:0] position_r;
  logic signed [sspc_pkg::POS_W-1:0] target_r, target_nxt;
  logic [sspc_pkg::STEP_W-1:0]       wait_r, wait_nxt;
  logic                              energized_r, energized_nxt;
  logic [sspc_pkg::STEP_W-1:0]       wait_sum;
  logic [sspc_pkg::STEP_W-1:0]       wait_rem;

  assign wait_sum = wait_r + item.elapsed;
  assign wait_rem = wait_sum - step_period;

  always_comb begin
    position_nxt  = position_r;
    target_nxt    = target_r;
    wait_nxt      = wait_r;
    energized_nxt = energized_r;
    case (item.kind)
      sspc_pkg::KIND_TICK: begin
        wait_nxt = wait_sum;
        if (wait_sum >= step_period) begin
          wait_nxt = (wait_rem > (step_period >> 2)) ? '0 : wait_rem;
          if (position_r < target_r) begin
            position_nxt  = position_r + 32'sd1;
            energized_nxt = 1'b1;
          end else if (target_r < position_r) begin
            position_nxt  = position_r - 32'sd1;
            energized_nxt = 1'b1;
          end else begin
            energized_nxt = 1'b0;
          end
        end
      end
      sspc_pkg::KIND_TARGET: begin
        target_nxt = item.target_position;
      end
      default: begin
      end
    endcase
  end

  // wave drive: one coil per position modulo four
  assign coils_nxt = energized_nxt ? (4'b0001 << position_nxt[1:0]) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r  <= '0;
      target_r    <= '0;
      wait_r      <= '0;
      energized_r <= 1'b1;
    end else if (upd) begin
      position_r  <= position_nxt;
      target_r    <= target_nxt;
      wait_r      <= wait_nxt;
      energized_r <= energized_nxt;
    end
  end

endmodule

// File: rtl/sspc_solenoid.sv
// solenoid pulse timer: drive flag and on-time accumulator
module sspc_solenoid (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          upd,
  input  sspc_pkg::in_item_t            item,
  input  logic [sspc_pkg::PULSE_W-1:0]  pulse_length,
  output logic                          active_nxt
);

  logic                          active_r;
  logic [sspc_pkg::PULSE_W-1:0]  wait_r, wait_nxt;
  logic [sspc_pkg::PULSE_W-1:0]  wait_sum;

  assign wait_sum = wait_r + {{(sspc_pkg::PULSE_W-sspc_pkg::STEP_W){1'b0}}, item.elapsed};

  always_comb begin
    active_nxt = active_r;
    wait_nxt   = wait_r;
    case (item.kind)
      sspc_pkg::KIND_TICK: begin
        if (active_r) begin
          if (wait_sum >= pulse_length) begin
            active_nxt = 1'b0;
            wait_nxt   = '0;
          end else begin
            wait_nxt = wait_sum;
          end
        end
      end
      sspc_pkg::KIND_PULSE: begin
        active_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      wait_r   <= '0;
    end else if (upd) begin
      active_r <= active_nxt;
      wait_r   <= wait_nxt;
    end
  end

endmodule

// File: rtl/stepper_and_solenoid_pulse_controller.sv
// top level of the stepper and solenoid pulse controller
// Each item (a tick with elapsed microseconds, a solenoid pulse command or a
// new signed stepper target) gives exactly one result: the coil drives, the
// solenoid drive and the stepper position after that item. An accepted item
// sits in the input register; when the result register is empty or being
// read, its state update is worked out and written together with the result
// register, and the block takes one item per clock while out_ready is high.
// While a result waits on a low out_ready, the item behind it stays in the
// input register and in_ready is low. Configuration writes (index 0 step
// period, index 1 pulse length) take effect at once and are meant to be
// issued while the block is idle.
module stepper_and_solenoid_pulse_controller (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  sspc_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sspc_pkg::out_item_t                  out_item,
  input  logic                                 cfg_we,
  input  logic [sspc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sspc_pkg::CFG_W-1:0]           cfg_data
);

  logic                                 s1_valid_r;
  sspc_pkg::in_item_t                   s1_item_r;
  logic                                 out_valid_r;
  sspc_pkg::out_item_t                  out_item_r, out_item_nxt;
  logic                                 advance;
  logic [sspc_pkg::STEP_W-1:0]          step_period_r;
  logic [sspc_pkg::PULSE_W-1:0]         pulse_length_r;
  logic [sspc_pkg::COILS-1:0]           coils_nxt;
  logic signed [sspc_pkg::POS_W-1:0]    position_nxt;
  logic                                 active_nxt;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_period_r  <= sspc_pkg::STEP_PERIOD_RST;
      pulse_length_r <= sspc_pkg::PULSE_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sspc_pkg::CFG_STEP_PERIOD:  step_period_r  <= cfg_data[sspc_pkg::STEP_W-1:0];
        sspc_pkg::CFG_PULSE_LENGTH: pulse_length_r <= cfg_data[sspc_pkg::PULSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  sspc_stepper u_stepper (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd          (advance),
    .item         (s1_item_r),
    .step_period  (step_period_r),
    .coils_nxt    (coils_nxt),
    .position_nxt (position_nxt)
  );

  sspc_solenoid u_solenoid (
    .clk          (clk),
    .rst_n        (rst_n),
    .upd          (advance),
    .item         (s1_item_r),
    .pulse_length (pulse_length_r),
    .active_nxt   (active_nxt)
  );

  always_comb begin
    out_item_nxt.coils            = coils_nxt;
    out_item_nxt.solenoid_drive   = active_nxt;
    out_item_nxt.current_position = position_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule

// File: rtl/sspc_checker.sv
// port-level checks for the stepper and solenoid pulse controller
module sspc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input sspc_pkg::out_item_t             out_item
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_coils_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_item.coils))
    else $error("more than one coil driven");

  a_coil_matches_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.coils != 4'b0000 |->
      out_item.coils == (4'b0001 << out_item.current_position[1:0]))
    else $error("driven coil does not match position");

endmodule

bind stepper_and_solenoid_pulse_controller sspc_checker u_sspc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
